FILE: hw/rtl/buddy_block_allocator_core_defines.svh
// shared assertion macros
`ifndef BUDDY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define BBA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bba assertion failed");

// next-cycle implication
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bba assertion failed");

`endif

FILE: hw/rtl/bba_pkg.sv
`default_nettype none
package bba_pkg;

    localparam int MAX_POWER    = 12;
    localparam int REGION_POW   = 12;
    localparam int MAX_LENGTH   = 2048;
    localparam int HEADER_BYTES = 8;

    localparam int TOP_LEVEL = (MAX_POWER < REGION_POW) ? MAX_POWER : REGION_POW;

    localparam int LEN_W = 12;
    localparam int OFF_W = 12;
    localparam int POW_W = 4;
    localparam int TOT_W = LEN_W + 1;

    localparam int MAP_SIZE  = 2 << REGION_POW;
    localparam int ADDR_W    = REGION_POW + 1;
    localparam int ROW_BITS  = 64;
    localparam int WB        = 6;
    localparam int PAIR_W    = ROW_BITS / 2;
    localparam int RAM_DEPTH = MAP_SIZE / ROW_BITS;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam int ROW_W     = ADDR_W - WB;
    localparam int SLOT_W    = REGION_POW;
    localparam int LVL_W     = $clog2(TOT_W + REGION_POW + 2);
    localparam int TOP_ROW   = (MAP_SIZE - 2) / ROW_BITS;
    localparam int TOP_BIT   = (MAP_SIZE - 2) % ROW_BITS;

    typedef struct packed {
        logic              kind;
        logic [LEN_W-1:0]  request_length;
        logic [OFF_W-1:0]  block_offset;
        logic [POW_W-1:0]  block_power;
    } t_in;

    typedef struct packed {
        logic              ok;
        logic [OFF_W-1:0]  granted_offset;
        logic [POW_W-1:0]  granted_power;
    } t_out;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_FIND_RD,
        S_FIND_CK,
        S_FIND_END,
        S_MRG_RD,
        S_MRG_WC,
        S_MRG_PRD,
        S_MRG_PWR,
        S_BIT_RD,
        S_BIT_WR,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        FP_FIRST,
        FP_SECOND,
        FP_UPPER
    } t_fphase;

    typedef enum logic [1:0] {
        BO_FREE,
        BO_GRANT,
        BO_SPLIT_TOP,
        BO_SPLIT
    } t_bop;

    function automatic logic [ADDR_W-1:0] level_base(input logic [LVL_W-1:0] lvl);
        int v;
        v = 0;
        if (int'(lvl) <= REGION_POW) begin
            v = MAP_SIZE - (2 << (REGION_POW - int'(lvl)));
        end
        return ADDR_W'(v);
    endfunction

    function automatic int level_slots(input logic [LVL_W-1:0] lvl);
        int v;
        v = 0;
        if (int'(lvl) <= REGION_POW) begin
            v = 1 << (REGION_POW - int'(lvl));
        end
        return v;
    endfunction

    function automatic int level_rows(input logic [LVL_W-1:0] lvl);
        return (level_slots(lvl) + ROW_BITS - 1) >> WB;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/bba_ram.sv
`default_nettype none
module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/buddy_block_allocator_core.sv
`default_nettype none
// Buddy allocator over a 4 KiB region with one free bit per block slot per level,
// kept in a 128 x 64-bit RAM. Issue an item with start while busy is low; the
// result appears on o_result for exactly one cycle with o_valid and must be taken
// then, since the block cannot be stalled. After reset a clearing pass writes all
// 128 RAM rows with busy high. A free decodes, reads the row holding its bit and
// sets it. An allocate that finds its level nonempty scans that level's rows and
// then clears the found bit; otherwise a merge pass reads each 64-bit row of every
// level below the requested one, clears merged child pairs and sets their parent
// bits, and each split writes one bit per level. All of this runs through one row
// search/merge unit and the single RAM read port, one row access at a time.
`include "buddy_block_allocator_core_defines.svh"
module buddy_block_allocator_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    input  wire bba_pkg::t_in i_item,
    output logic              busy,
    output logic              o_valid,
    output bba_pkg::t_out     o_result
);
    import bba_pkg::*;

    t_state                r_state, n_state;
    t_in                   r_item;
    t_fphase               r_fph;
    t_bop                  r_bop;
    t_out                  r_res;
    logic                  r_done, n_done;
    logic [LVL_W-1:0]      r_lvl;
    logic [LVL_W-1:0]      r_pow;
    logic [ROW_W-1:0]      r_row;
    logic [SLOT_W-1:0]     r_slot;
    logic                  r_hit;
    logic [PAIR_W-1:0]     r_merge;
    logic [RAM_AW-1:0]     r_clr;

    logic                  ram_we;
    logic [RAM_AW-1:0]     ram_waddr, ram_raddr;
    logic [ROW_BITS-1:0]   ram_wdata, ram_rdata;

    logic [ADDR_W-1:0]     c_addr, p_addr, b_addr;
    logic [SLOT_W-1:0]     b_slot;
    logic                  b_set;
    int                    c_n;
    logic [ROW_BITS-1:0]   c_mask, c_bits, c_clr;
    logic [PAIR_W-1:0]     c_pairs;
    logic [WB-1:0]         f_idx;
    logic                  f_hit;
    logic [SLOT_W-1:0]     f_slot;
    logic                  row_last;
    int                    s_stop;
    logic [TOT_W-1:0]      d_total;
    logic [LVL_W-1:0]      d_pow;
    logic                  d_alloc_bad, d_free_bad;
    logic [ROW_BITS-1:0]   w_child, w_parent, w_bit;

    bba_ram #(
        .WIDTH(ROW_BITS),
        .DEPTH(RAM_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // decode
    always_comb begin
        d_total = TOT_W'(r_item.request_length) + TOT_W'(HEADER_BYTES);
        d_pow   = '0;
        for (int i = 0; i < TOT_W; i++) begin
            if (d_total[i]) begin
                d_pow = LVL_W'(i + 1);
            end
        end
        d_alloc_bad = (r_item.request_length == '0) ||
                      (32'(r_item.request_length) > 32'(MAX_LENGTH)) ||
                      (int'(d_pow) > MAX_POWER);
        d_free_bad  = (int'(r_item.block_power) > TOP_LEVEL) ||
                      ((r_item.block_offset &
                        OFF_W'((32'(1) << r_item.block_power) - 32'(1))) != '0) ||
                      (32'(r_item.block_offset) >= (32'(1) << REGION_POW));
        s_stop = (int'(r_pow) < TOP_LEVEL) ? int'(r_pow) : TOP_LEVEL;
    end

    // shared row unit
    always_comb begin
        c_addr = level_base(r_lvl) + (ADDR_W'(r_row) << WB);
        p_addr = level_base(r_lvl + LVL_W'(1)) + (ADDR_W'(r_row) << (WB - 1));
        b_slot = r_slot | SLOT_W'(r_bop == BO_SPLIT);
        b_addr = level_base(r_lvl) + ADDR_W'(b_slot);
        b_set  = (r_bop == BO_FREE) || (r_bop == BO_SPLIT);
        c_n    = level_slots(r_lvl) - (int'(r_row) << WB);
        if (c_n > ROW_BITS) begin
            c_n = ROW_BITS;
        end
        c_mask = (c_n >= ROW_BITS) ? '1 : ((ROW_BITS'(1) << c_n) - ROW_BITS'(1));
        c_bits = (ram_rdata >> c_addr[WB-1:0]) & c_mask;
        for (int k = 0; k < PAIR_W; k++) begin
            c_pairs[k]      = c_bits[2*k] & c_bits[2*k+1];
            c_clr[2*k]      = c_pairs[k];
            c_clr[2*k+1]    = c_pairs[k];
        end
        f_hit = |c_bits;
        f_idx = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--) begin
            if (c_bits[i]) begin
                f_idx = WB'(i);
            end
        end
        f_slot   = SLOT_W'((int'(r_row) << WB) + int'(f_idx));
        row_last = (int'(r_row) + 1) >= level_rows(r_lvl);
        w_child  = ram_rdata & ~(c_clr << c_addr[WB-1:0]);
        w_parent = ram_rdata | (ROW_BITS'(r_merge) << p_addr[WB-1:0]);
        w_bit    = b_set ? (ram_rdata | (ROW_BITS'(1) << b_addr[WB-1:0]))
                         : (ram_rdata & ~(ROW_BITS'(1) << b_addr[WB-1:0]));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == RAM_AW'(RAM_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (r_item.kind) begin
                    n_state = d_free_bad ? S_DONE : S_BIT_RD;
                end else begin
                    n_state = d_alloc_bad ? S_DONE : S_FIND_RD;
                end
            end
            S_FIND_RD: begin
                n_state = (int'(r_lvl) > TOP_LEVEL) ? S_FIND_END : S_FIND_CK;
            end
            S_FIND_CK: begin
                n_state = (f_hit || row_last) ? S_FIND_END : S_FIND_RD;
            end
            S_FIND_END: begin
                if (r_hit) begin
                    n_state = S_BIT_RD;
                end else begin
                    case (r_fph)
                        FP_FIRST:  n_state = (s_stop > 0) ? S_MRG_RD : S_FIND_RD;
                        FP_SECOND: n_state = S_FIND_RD;
                        default: begin
                            n_state = (int'(r_lvl) >= TOP_LEVEL) ? S_DONE : S_FIND_RD;
                        end
                    endcase
                end
            end
            S_MRG_RD:  n_state = S_MRG_WC;
            S_MRG_WC:  n_state = S_MRG_PRD;
            S_MRG_PRD: n_state = S_MRG_PWR;
            S_MRG_PWR: begin
                if (!row_last || (int'(r_lvl) + 1 < s_stop)) begin
                    n_state = S_MRG_RD;
                end else begin
                    n_state = S_FIND_RD;
                end
            end
            S_BIT_RD: n_state = S_BIT_WR;
            S_BIT_WR: begin
                case (r_bop)
                    BO_FREE, BO_GRANT: n_state = S_DONE;
                    BO_SPLIT_TOP:      n_state = S_BIT_RD;
                    default:           n_state = (r_lvl == r_pow) ? S_DONE : S_BIT_RD;
                endcase
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = c_addr[ADDR_W-1:WB];
        ram_wdata = w_child;
        ram_raddr = c_addr[ADDR_W-1:WB];
        n_done    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = (r_clr == RAM_AW'(TOP_ROW)) ? (ROW_BITS'(1) << TOP_BIT) : '0;
            end
            S_MRG_WC: begin
                ram_we = 1'b1;
            end
            S_MRG_PRD: begin
                ram_raddr = p_addr[ADDR_W-1:WB];
            end
            S_MRG_PWR: begin
                ram_we    = 1'b1;
                ram_waddr = p_addr[ADDR_W-1:WB];
                ram_wdata = w_parent;
            end
            S_BIT_RD: begin
                ram_raddr = b_addr[ADDR_W-1:WB];
            end
            S_BIT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = b_addr[ADDR_W-1:WB];
                ram_wdata = w_bit;
            end
            S_DONE: begin
                n_done = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + RAM_AW'(1);
                end
                S_IDLE: begin
                    r_item <= i_item;
                end
                S_DECODE: begin
                    r_res <= '0;
                    r_row <= '0;
                    if (r_item.kind) begin
                        r_lvl  <= LVL_W'(r_item.block_power);
                        r_slot <= SLOT_W'(r_item.block_offset >> r_item.block_power);
                        r_bop  <= BO_FREE;
                    end else begin
                        r_pow <= d_pow;
                        r_lvl <= d_pow;
                        r_fph <= FP_FIRST;
                    end
                end
                S_FIND_RD: begin
                    r_hit <= 1'b0;
                end
                S_FIND_CK: begin
                    r_hit  <= f_hit;
                    r_slot <= f_slot;
                    if (!f_hit && !row_last) begin
                        r_row <= r_row + ROW_W'(1);
                    end
                end
                S_FIND_END: begin
                    r_row <= '0;
                    if (r_hit) begin
                        r_bop <= (r_fph == FP_UPPER) ? BO_SPLIT_TOP : BO_GRANT;
                    end else begin
                        case (r_fph)
                            FP_FIRST: begin
                                if (s_stop > 0) begin
                                    r_lvl <= '0;
                                end else begin
                                    r_fph <= FP_SECOND;
                                end
                            end
                            FP_SECOND: begin
                                r_fph <= FP_UPPER;
                                r_lvl <= r_lvl + LVL_W'(1);
                            end
                            default: begin
                                r_lvl <= r_lvl + LVL_W'(1);
                            end
                        endcase
                    end
                end
                S_MRG_WC: begin
                    r_merge <= c_pairs;
                end
                S_MRG_PWR: begin
                    if (!row_last) begin
                        r_row <= r_row + ROW_W'(1);
                    end else if (int'(r_lvl) + 1 < s_stop) begin
                        r_row <= '0;
                        r_lvl <= r_lvl + LVL_W'(1);
                    end else begin
                        r_row <= '0;
                        r_lvl <= r_pow;
                        r_fph <= FP_SECOND;
                    end
                end
                S_BIT_WR: begin
                    case (r_bop)
                        BO_FREE: begin
                            r_res.ok <= 1'b1;
                        end
                        BO_GRANT: begin
                            r_res.ok             <= 1'b1;
                            r_res.granted_offset <= OFF_W'(32'(r_slot) << r_pow);
                            r_res.granted_power  <= POW_W'(r_pow);
                        end
                        BO_SPLIT_TOP: begin
                            r_lvl  <= r_lvl - LVL_W'(1);
                            r_slot <= r_slot << 1;
                            r_bop  <= BO_SPLIT;
                        end
                        default: begin
                            if (r_lvl == r_pow) begin
                                r_res.ok             <= 1'b1;
                                r_res.granted_offset <= OFF_W'(32'(r_slot) << r_pow);
                                r_res.granted_power  <= POW_W'(r_pow);
                            end else begin
                                r_lvl  <= r_lvl - LVL_W'(1);
                                r_slot <= r_slot << 1;
                            end
                        end
                    endcase
                end
                default: begin
                    r_clr <= r_clr;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_done;
    assign o_result = r_res;

    `BBA_ASSERT_NEXT(a_single_strobe, o_valid, !o_valid)
    `BBA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `BBA_ASSERT_NOW(a_fail_zero, o_valid && !o_result.ok,
                    (o_result.granted_offset == '0) && (o_result.granted_power == '0))

endmodule
`default_nettype wire
